// File: sv/ipsp_pkg.sv
// Shared types, codes and constants of the IPS patch stream parser.
`timescale 1ns / 1ps

package ipsp_pkg;

    localparam int SIZE_W   = 25;
    localparam int OFFS_W   = 24;
    localparam int LEN_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int FBC_W    = 3;
    localparam int KIND_W   = 2;
    localparam int ERR_W    = 3;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam int OUT_FIFO_DEPTH = 4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_ORIGINAL_SIZE = 1'b0;

    // Field lengths in bytes
    localparam logic [FBC_W-1:0] HDR_BYTES    = 3'd5;
    localparam logic [FBC_W-1:0] HDR_LAST_IDX = 3'd4;
    localparam logic [FBC_W-1:0] OFFS_BYTES   = 3'd3;
    localparam logic [FBC_W-1:0] LEN_BYTES    = 3'd2;

    localparam logic [OFFS_W-1:0] EOF_MARK = 24'h454F46;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_HEADER   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_OFFSET   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_LENGTH   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_RUNCOUNT = 3'd3;
    localparam logic [ERR_W-1:0] ERR_DATA     = 3'd4;

    typedef enum logic [6:0] {
        PH_HEADER   = 7'b0000001,
        PH_OFFSET   = 7'b0000010,
        PH_LENGTH   = 7'b0000100,
        PH_RUNCOUNT = 7'b0001000,
        PH_VALUE    = 7'b0010000,
        PH_DATA     = 7'b0100000,
        PH_DONE     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SIZE_W-1:0] address;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  count;
        logic [SIZE_W-1:0] new_size;
        logic [ERR_W-1:0]  error_code;
        logic              last;
    } result_t;

    // Up to two results per byte beat: a write, then a status
    typedef struct packed {
        logic    wr_valid;
        logic    st_valid;
        result_t wr;
        result_t st;
    } push_t;

    // "PATCH"
    function automatic logic [BYTE_W-1:0] ipsp_magic(input logic [FBC_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h50;
            3'd1:    b = 8'h41;
            3'd2:    b = 8'h54;
            3'd3:    b = 8'h43;
            3'd4:    b = 8'h48;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/ipsp_parse.sv
// Byte-level parse step: record state registers and result generation.
`timescale 1ns / 1ps

module ipsp_parse (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ipsp_pkg::SIZE_W-1:0]  original_size,
    input  logic                         accept,
    input  logic [ipsp_pkg::BYTE_W-1:0]  patch_byte,
    input  logic                         end_of_patch,
    output ipsp_pkg::push_t              push
);
    import ipsp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [FBC_W-1:0]  fbc_reg, fbc_next;
    logic [OFFS_W-1:0] offset_reg, offset_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [SIZE_W-1:0] wptr_reg, wptr_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    logic [FBC_W-1:0]  fbc_inc;
    logic [OFFS_W-1:0] off_shift;
    logic [LEN_W-1:0]  len_shift;
    logic [LEN_W-1:0]  remain_dec;
    logic [SIZE_W-1:0] end_sum;
    logic [SIZE_W-1:0] grown_size;
    logic              is_len;

    logic              wr_v, st_v;
    logic [SIZE_W-1:0] wr_addr;
    logic [LEN_W-1:0]  wr_count;
    logic [KIND_W-1:0] st_kind;
    logic [ERR_W-1:0]  st_err;
    logic [SIZE_W-1:0] st_size;

    assign fbc_inc    = fbc_reg + 3'd1;
    assign off_shift  = (fbc_reg == '0) ? {16'h0000, patch_byte}
                                        : {offset_reg[15:0], patch_byte};
    assign len_shift  = (fbc_reg == '0) ? {8'h00, patch_byte}
                                        : {length_reg[7:0], patch_byte};
    assign remain_dec = remain_reg - 16'd1;
    assign end_sum    = {1'b0, offset_reg} + {9'h000, len_shift};
    assign grown_size = (end_sum > size_reg) ? end_sum : size_reg;
    assign is_len     = (phase_reg == PH_LENGTH);

    always_comb
    begin
        phase_next  = phase_reg;
        fbc_next    = fbc_reg;
        offset_next = offset_reg;
        length_next = length_reg;
        remain_next = remain_reg;
        wptr_next   = wptr_reg;
        size_next   = size_reg;
        wr_v        = 1'b0;
        wr_addr     = '0;
        wr_count    = '0;
        st_v        = 1'b0;
        st_kind     = KIND_DONE;
        st_err      = '0;
        st_size     = '0;

        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (fbc_reg == '0)
                        size_next = original_size;
                    if (fbc_reg > HDR_LAST_IDX || patch_byte != ipsp_magic(fbc_reg))
                    begin
                        st_v       = 1'b1;
                        st_kind    = KIND_FAIL;
                        st_err     = ERR_HEADER;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        fbc_next = fbc_inc;
                        if (fbc_inc == HDR_BYTES)
                        begin
                            fbc_next   = '0;
                            phase_next = PH_OFFSET;
                            if (end_of_patch)
                            begin
                                st_v    = 1'b1;
                                st_kind = KIND_DONE;
                                st_size = size_reg;
                            end
                        end
                        else if (end_of_patch)
                        begin
                            st_v    = 1'b1;
                            st_kind = KIND_FAIL;
                            st_err  = ERR_HEADER;
                        end
                    end
                end

                PH_OFFSET:
                begin
                    offset_next = off_shift;
                    fbc_next    = fbc_inc;
                    if (fbc_inc < OFFS_BYTES)
                    begin
                        if (end_of_patch)
                        begin
                            st_v    = 1'b1;
                            st_kind = KIND_FAIL;
                            st_err  = ERR_OFFSET;
                        end
                    end
                    else
                    begin
                        fbc_next = '0;
                        if (off_shift == EOF_MARK)
                        begin
                            st_v       = 1'b1;
                            st_kind    = KIND_DONE;
                            st_size    = size_reg;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_LENGTH;
                            if (end_of_patch)
                            begin
                                st_v    = 1'b1;
                                st_kind = KIND_FAIL;
                                st_err  = ERR_LENGTH;
                            end
                        end
                    end
                end

                PH_LENGTH, PH_RUNCOUNT:
                begin
                    length_next = len_shift;
                    fbc_next    = fbc_inc;
                    if (fbc_inc < LEN_BYTES)
                    begin
                        if (end_of_patch)
                        begin
                            st_v    = 1'b1;
                            st_kind = KIND_FAIL;
                            st_err  = is_len ? ERR_LENGTH : ERR_RUNCOUNT;
                        end
                    end
                    else
                    begin
                        fbc_next = '0;
                        if (is_len && len_shift == '0)
                        begin
                            // zero length: fill record follows
                            phase_next = PH_RUNCOUNT;
                            if (end_of_patch)
                            begin
                                st_v    = 1'b1;
                                st_kind = KIND_FAIL;
                                st_err  = ERR_RUNCOUNT;
                            end
                        end
                        else if (is_len)
                        begin
                            size_next   = grown_size;
                            wptr_next   = {1'b0, offset_reg};
                            remain_next = len_shift;
                            phase_next  = PH_DATA;
                            if (end_of_patch)
                            begin
                                st_v    = 1'b1;
                                st_kind = KIND_FAIL;
                                st_err  = ERR_DATA;
                            end
                        end
                        else
                        begin
                            size_next  = grown_size;
                            phase_next = PH_VALUE;
                            if (end_of_patch)
                            begin
                                st_v = 1'b1;
                                if (len_shift == '0)
                                begin
                                    st_kind = KIND_DONE;
                                    st_size = grown_size;
                                end
                                else
                                begin
                                    st_kind = KIND_FAIL;
                                    st_err  = ERR_DATA;
                                end
                            end
                        end
                    end
                end

                PH_VALUE:
                begin
                    // empty run count emits nothing but still eats the value byte
                    if (length_reg != '0)
                    begin
                        wr_v     = 1'b1;
                        wr_addr  = {1'b0, offset_reg};
                        wr_count = length_reg;
                    end
                    phase_next = PH_OFFSET;
                    if (end_of_patch)
                    begin
                        st_v    = 1'b1;
                        st_kind = KIND_DONE;
                        st_size = size_reg;
                    end
                end

                PH_DATA:
                begin
                    wr_v        = 1'b1;
                    wr_addr     = wptr_reg;
                    wr_count    = 16'd1;
                    wptr_next   = wptr_reg + 25'd1;
                    remain_next = remain_dec;
                    if (remain_dec == '0)
                    begin
                        phase_next = PH_OFFSET;
                        if (end_of_patch)
                        begin
                            st_v    = 1'b1;
                            st_kind = KIND_DONE;
                            st_size = size_reg;
                        end
                    end
                    else if (end_of_patch)
                    begin
                        st_v    = 1'b1;
                        st_kind = KIND_FAIL;
                        st_err  = ERR_DATA;
                    end
                end

                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end

                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase

            if (st_v)
                phase_next = PH_DONE;

            // the flagged byte always rearms for a new header
            if (end_of_patch)
            begin
                phase_next = PH_HEADER;
                fbc_next   = '0;
            end
        end
    end

    always_comb
    begin
        push.wr_valid      = wr_v;
        push.st_valid      = st_v;
        push.wr.kind       = KIND_WRITE;
        push.wr.address    = wr_addr;
        push.wr.data       = patch_byte;
        push.wr.count      = wr_count;
        push.wr.new_size   = '0;
        push.wr.error_code = '0;
        push.wr.last       = ~st_v;
        push.st.kind       = st_kind;
        push.st.address    = '0;
        push.st.data       = '0;
        push.st.count      = '0;
        push.st.new_size   = st_size;
        push.st.error_code = st_err;
        push.st.last       = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            fbc_reg    <= '0;
            offset_reg <= '0;
            length_reg <= '0;
            remain_reg <= '0;
            wptr_reg   <= '0;
            size_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fbc_reg    <= fbc_next;
            offset_reg <= offset_next;
            length_reg <= length_next;
            remain_reg <= remain_next;
            wptr_reg   <= wptr_next;
            size_reg   <= size_next;
        end
    end

endmodule

// File: sv/ipsp_out_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
`timescale 1ns / 1ps

module ipsp_out_fifo #(
    parameter int DEPTH = ipsp_pkg::OUT_FIFO_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ipsp_pkg::push_t      push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ipsp_pkg::result_t    head
);
    import ipsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PTR_W-1:0]   wr_ptr_1;
    logic               first_v, both_v, pop;
    result_t            first;
    logic [CNT_W-1:0]   n_push;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign first_v  = push.wr_valid | push.st_valid;
    assign both_v   = push.wr_valid & push.st_valid;
    assign first    = push.wr_valid ? push.wr : push.st;
    assign wr_ptr_1 = ptr_inc(wr_ptr_reg);
    assign n_push   = CNT_W'(push.wr_valid) + CNT_W'(push.st_valid);
    assign pop      = out_valid & out_ready;

    assign out_valid = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];
    // a byte beat may bring two results
    assign room      = (cnt_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (both_v)
            wr_ptr_next = ptr_inc(wr_ptr_1);
        else if (first_v)
            wr_ptr_next = wr_ptr_1;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + n_push - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (first_v)
            mem[wr_ptr_reg] <= first;
        if (both_v)
            mem[wr_ptr_1] <= push.st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: sv/ips_patch_stream_parser_unit.sv
// Top level of the IPS patch stream parser: config register, parse step, result queue.
// Output: results of a byte beat are queued at its accept edge and reach the output
//   behind any results that are already queued.
// Throughput: one byte beat per cycle; in_ready drops only while the result queue has
//   fewer than two free slots, which a consumer that keeps up never lets happen.
// Reset (rst_n, async, low): parser waits for the header, queue empties, original_size = 0.
`timescale 1ns / 1ps

module ips_patch_stream_parser_unit #(
    parameter int OUT_DEPTH = ipsp_pkg::OUT_FIFO_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // APB-style config port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ipsp_pkg::ADDR_W-1:0]    paddr,
    input  logic [ipsp_pkg::DATA_W-1:0]    pwdata,
    output logic [ipsp_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,

    // patch byte beats
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ipsp_pkg::BYTE_W-1:0]    patch_byte,
    input  logic                           end_of_patch,

    // result beats
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [ipsp_pkg::KIND_W-1:0]    kind,
    output logic [ipsp_pkg::SIZE_W-1:0]    address,
    output logic [ipsp_pkg::BYTE_W-1:0]    data,
    output logic [ipsp_pkg::LEN_W-1:0]     count,
    output logic [ipsp_pkg::SIZE_W-1:0]    new_size,
    output logic [ipsp_pkg::ERR_W-1:0]     error_code,
    output logic                           last
);
    import ipsp_pkg::*;

    logic [SIZE_W-1:0]    orig_size_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;
    logic                 accept;
    logic                 room;
    push_t                push;
    result_t              head;

    // --- config register --------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready & (reg_idx == REG_ORIGINAL_SIZE);

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_ORIGINAL_SIZE)
            prdata = {{(DATA_W - SIZE_W){1'b0}}, orig_size_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            orig_size_reg <= '0;
        else if (cfg_wr)
            orig_size_reg <= pwdata[SIZE_W-1:0];
    end

    // --- input handshake --------------------------------------------------
    // Ready depends only on queue fill, not on parser phase: a new byte
    // goes in every cycle while the consumer keeps up.
    assign in_ready = room;
    assign accept   = in_valid & in_ready;

    // --- one parse step per accepted byte beat ----------------------------
    ipsp_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .original_size (orig_size_reg),
        .accept        (accept),
        .patch_byte    (patch_byte),
        .end_of_patch  (end_of_patch),
        .push          (push)
    );

    // --- result queue: write run first, then finish/fail status -----------
    ipsp_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind       = head.kind;
    assign address    = head.address;
    assign data       = head.data;
    assign count      = head.count;
    assign new_size   = head.new_size;
    assign error_code = head.error_code;
    assign last       = head.last;

endmodule
